@@ hdl/uitp_pkg.sv @@
// ----------------------------------------------------------------------------
// uitp_pkg
// Shared types and constants for the user-information TLV record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package uitp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_NAME    = 4'd1,
    PH_WARN_HI = 4'd2,
    PH_WARN_LO = 4'd3,
    PH_CNT_HI  = 4'd4,
    PH_CNT_LO  = 4'd5,
    PH_TYP_HI  = 4'd6,
    PH_TYP_LO  = 4'd7,
    PH_LEN_HI  = 4'd8,
    PH_LEN_LO  = 4'd9,
    PH_VALUE   = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  localparam logic [15:0] TYPE_CLASS   = 16'h0001;
  localparam logic [15:0] TYPE_SINCE   = 16'h0002;
  localparam logic [15:0] TYPE_ONLINE  = 16'h0003;
  localparam logic [15:0] TYPE_IDLE    = 16'h0004;
  localparam logic [15:0] TYPE_SESS_A  = 16'h000f;
  localparam logic [15:0] TYPE_SESS_B  = 16'h0010;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_char;
    logic [15:0] warn_level;
    logic [15:0] member_class;
    logic [31:0] member_since;
    logic [31:0] online_since;
    logic [15:0] idle_seconds;
    logic [31:0] session_length;
    logic [15:0] bytes_used;
    logic        unknown_seen;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/uitp_if.sv @@
// ----------------------------------------------------------------------------
// uitp_if
// Valid/ready channels for record bytes in and parser results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface uitp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface uitp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  name_char;
  logic [15:0] warn_level;
  logic [15:0] member_class;
  logic [31:0] member_since;
  logic [31:0] online_since;
  logic [15:0] idle_seconds;
  logic [31:0] session_length;
  logic [15:0] bytes_used;
  logic        unknown_seen;

  modport source (
    output valid, input ready,
    output result_kind, output name_char, output warn_level, output member_class,
    output member_since, output online_since, output idle_seconds,
    output session_length, output bytes_used, output unknown_seen
  );
  modport sink (
    input valid, output ready,
    input result_kind, input name_char, input warn_level, input member_class,
    input member_since, input online_since, input idle_seconds,
    input session_length, input bytes_used, input unknown_seen
  );
endinterface

`default_nettype wire

@@ hdl/uitp_in_stage.sv @@
// ----------------------------------------------------------------------------
// uitp_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uitp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire uitp_pkg::in_item_t in_item,
  output logic                   in_ready,
  output logic                   hold_valid,
  output uitp_pkg::in_item_t     hold_item,
  input  wire logic              take
);

  logic               valid_r;
  uitp_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/uitp_parse.sv @@
// ----------------------------------------------------------------------------
// uitp_parse
// Record state machine and field stores; one byte per cycle while take is high.
// ----------------------------------------------------------------------------
`default_nettype none

module uitp_parse (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire uitp_pkg::in_item_t item,
  output logic                    res_valid,
  output uitp_pkg::result_t       res
);

  uitp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  name_rem_r,  name_rem_nxt;
  logic [15:0] entries_r,   entries_nxt;
  logic [15:0] etype_r,     etype_nxt;
  logic [15:0] elen_r,      elen_nxt;
  logic [15:0] vpos_r,      vpos_nxt;
  logic [31:0] vshift_r,    vshift_nxt;
  logic        class_tk_r,  class_tk_nxt;
  logic [15:0] warn_r,      warn_nxt;
  logic [15:0] class_r,     class_nxt;
  logic [31:0] since_r,     since_nxt;
  logic [31:0] online_r,    online_nxt;
  logic [15:0] idle_r,      idle_nxt;
  logic [31:0] sess_r,      sess_nxt;
  logic [15:0] count_r,     count_nxt;
  logic        unk_r,       unk_nxt;

  logic [7:0]  b;
  logic        start;
  logic        active;
  logic [15:0] cnt_full;
  logic [15:0] len_full;
  logic [15:0] vpos_inc;
  logic        last_entry;
  logic        wide;
  logic        narrow;
  logic [31:0] merged;
  logic        commit;
  logic [31:0] commit_val;

  assign b          = item.data_byte;
  assign start      = item.record_start;
  assign active     = (phase_r != uitp_pkg::PH_IDLE) && (phase_r != uitp_pkg::PH_DONE);
  assign cnt_full   = {entries_r[15:8], b};
  assign len_full   = {elen_r[15:8], b};
  assign vpos_inc   = vpos_r + 16'd1;
  assign last_entry = (entries_r == 16'd1);
  assign wide       = etype_r inside {uitp_pkg::TYPE_SINCE, uitp_pkg::TYPE_ONLINE,
                                      uitp_pkg::TYPE_SESS_A, uitp_pkg::TYPE_SESS_B};
  assign narrow     = etype_r inside {uitp_pkg::TYPE_CLASS, uitp_pkg::TYPE_IDLE};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      phase_nxt = (b != 8'd0) ? uitp_pkg::PH_NAME : uitp_pkg::PH_WARN_HI;
    end else begin
      case (phase_r)
        uitp_pkg::PH_NAME: begin
          if (name_rem_r == 8'd1) phase_nxt = uitp_pkg::PH_WARN_HI;
        end
        uitp_pkg::PH_WARN_HI: phase_nxt = uitp_pkg::PH_WARN_LO;
        uitp_pkg::PH_WARN_LO: phase_nxt = uitp_pkg::PH_CNT_HI;
        uitp_pkg::PH_CNT_HI:  phase_nxt = uitp_pkg::PH_CNT_LO;
        uitp_pkg::PH_CNT_LO: begin
          phase_nxt = (cnt_full == 16'd0) ? uitp_pkg::PH_DONE : uitp_pkg::PH_TYP_HI;
        end
        uitp_pkg::PH_TYP_HI:  phase_nxt = uitp_pkg::PH_TYP_LO;
        uitp_pkg::PH_TYP_LO:  phase_nxt = uitp_pkg::PH_LEN_HI;
        uitp_pkg::PH_LEN_HI:  phase_nxt = uitp_pkg::PH_LEN_LO;
        uitp_pkg::PH_LEN_LO: begin
          if (len_full != 16'd0) begin
            phase_nxt = uitp_pkg::PH_VALUE;
          end else begin
            phase_nxt = last_entry ? uitp_pkg::PH_DONE : uitp_pkg::PH_TYP_HI;
          end
        end
        uitp_pkg::PH_VALUE: begin
          if (vpos_inc == elen_r) begin
            phase_nxt = last_entry ? uitp_pkg::PH_DONE : uitp_pkg::PH_TYP_HI;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // merge the current value byte, big-endian from the top of the field
  always_comb begin
    merged = vshift_r;
    if (wide && (vpos_r < 16'd4)) begin
      case (vpos_r[1:0])
        2'd0:    merged[31:24] = b;
        2'd1:    merged[23:16] = b;
        2'd2:    merged[15:8]  = b;
        default: merged[7:0]   = b;
      endcase
    end else if (narrow && (vpos_r < 16'd2)) begin
      if (vpos_r[0]) merged[7:0] = b;
      else           merged[15:8] = b;
    end
  end

  // stores, counters and result
  always_comb begin
    name_rem_nxt = name_rem_r;
    entries_nxt  = entries_r;
    etype_nxt    = etype_r;
    elen_nxt     = elen_r;
    vpos_nxt     = vpos_r;
    vshift_nxt   = vshift_r;
    class_tk_nxt = class_tk_r;
    warn_nxt     = warn_r;
    class_nxt    = class_r;
    since_nxt    = since_r;
    online_nxt   = online_r;
    idle_nxt     = idle_r;
    sess_nxt     = sess_r;
    count_nxt    = count_r;
    unk_nxt      = unk_r;
    commit       = 1'b0;
    commit_val   = 32'd0;

    if (start) begin
      name_rem_nxt = b;
      entries_nxt  = 16'd0;
      etype_nxt    = 16'd0;
      elen_nxt     = 16'd0;
      vpos_nxt     = 16'd0;
      vshift_nxt   = 32'd0;
      class_tk_nxt = 1'b0;
      warn_nxt     = 16'd0;
      class_nxt    = 16'd0;
      since_nxt    = 32'd0;
      online_nxt   = 32'd0;
      idle_nxt     = 16'd0;
      sess_nxt     = 32'd0;
      count_nxt    = 16'd1;
      unk_nxt      = 1'b0;
    end else if (active) begin
      if (count_r != uitp_pkg::COUNT_MAX) count_nxt = count_r + 16'd1;
      case (phase_r)
        uitp_pkg::PH_NAME:    name_rem_nxt = name_rem_r - 8'd1;
        uitp_pkg::PH_WARN_HI: warn_nxt = {b, 8'd0};
        uitp_pkg::PH_WARN_LO: warn_nxt = {warn_r[15:8], b};
        uitp_pkg::PH_CNT_HI:  entries_nxt = {b, 8'd0};
        uitp_pkg::PH_CNT_LO:  entries_nxt = cnt_full;
        uitp_pkg::PH_TYP_HI:  etype_nxt = {b, 8'd0};
        uitp_pkg::PH_TYP_LO:  etype_nxt = {etype_r[15:8], b};
        uitp_pkg::PH_LEN_HI:  elen_nxt = {b, 8'd0};
        uitp_pkg::PH_LEN_LO: begin
          elen_nxt   = len_full;
          vpos_nxt   = 16'd0;
          vshift_nxt = 32'd0;
          if (len_full == 16'd0) begin
            commit     = 1'b1;
            commit_val = 32'd0;
          end
        end
        uitp_pkg::PH_VALUE: begin
          vpos_nxt   = vpos_inc;
          vshift_nxt = merged;
          if (vpos_inc == elen_r) begin
            commit     = 1'b1;
            commit_val = merged;
          end
        end
        default: count_nxt = count_r;
      endcase
    end

    if (commit) begin
      entries_nxt = entries_r - 16'd1;
      case (etype_r)
        uitp_pkg::TYPE_CLASS: begin
          if (!class_tk_r) begin
            class_nxt    = commit_val[15:0];
            class_tk_nxt = 1'b1;
          end
        end
        uitp_pkg::TYPE_SINCE:  since_nxt  = commit_val;
        uitp_pkg::TYPE_ONLINE: online_nxt = commit_val;
        uitp_pkg::TYPE_IDLE:   idle_nxt   = commit_val[15:0];
        uitp_pkg::TYPE_SESS_A,
        uitp_pkg::TYPE_SESS_B: sess_nxt   = commit_val;
        default:               unk_nxt    = 1'b1;
      endcase
    end
  end

  // result
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (take && !start && phase_r == uitp_pkg::PH_NAME) begin
      res_valid        = 1'b1;
      res.result_kind  = uitp_pkg::KIND_CHAR;
      res.name_char    = b;
    end else if (take && !start && active && phase_nxt == uitp_pkg::PH_DONE) begin
      res_valid          = 1'b1;
      res.result_kind    = uitp_pkg::KIND_SUMMARY;
      res.warn_level     = warn_nxt;
      res.member_class   = class_nxt;
      res.member_since   = since_nxt;
      res.online_since   = online_nxt;
      res.idle_seconds   = idle_nxt;
      res.session_length = sess_nxt;
      res.bytes_used     = count_nxt;
      res.unknown_seen   = unk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= uitp_pkg::PH_IDLE;
      name_rem_r <= 8'd0;
      entries_r  <= 16'd0;
      etype_r    <= 16'd0;
      elen_r     <= 16'd0;
      vpos_r     <= 16'd0;
      vshift_r   <= 32'd0;
      class_tk_r <= 1'b0;
      warn_r     <= 16'd0;
      class_r    <= 16'd0;
      since_r    <= 32'd0;
      online_r   <= 32'd0;
      idle_r     <= 16'd0;
      sess_r     <= 32'd0;
      count_r    <= 16'd0;
      unk_r      <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      name_rem_r <= name_rem_nxt;
      entries_r  <= entries_nxt;
      etype_r    <= etype_nxt;
      elen_r     <= elen_nxt;
      vpos_r     <= vpos_nxt;
      vshift_r   <= vshift_nxt;
      class_tk_r <= class_tk_nxt;
      warn_r     <= warn_nxt;
      class_r    <= class_nxt;
      since_r    <= since_nxt;
      online_r   <= online_nxt;
      idle_r     <= idle_nxt;
      sess_r     <= sess_nxt;
      count_r    <= count_nxt;
      unk_r      <= unk_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/uitp_out_stage.sv @@
// ----------------------------------------------------------------------------
// uitp_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uitp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_valid,
  input  wire uitp_pkg::result_t load_res,
  output logic                   free,
  output logic                   out_valid,
  output uitp_pkg::result_t      out_res,
  input  wire logic              out_ready
);

  logic              valid_r;
  uitp_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/user_info_tlv_parser_core.sv @@
// ----------------------------------------------------------------------------
// user_info_tlv_parser_core
// Byte-serial parser of user-information TLV records with name and summary
// results.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register until the result
// register is free; it is then parsed into the result register.
// Throughput: one byte per cycle while the result register is free, set by
// the single parse step between the input register and the result register.
// Reset: synchronous rst_n returns the parser to idle, clears all stores and
// empties both registers.
`default_nettype none

module user_info_tlv_parser_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  uitp_in_if.sink     in_req,
  uitp_out_if.source  out_res
);

  uitp_pkg::in_item_t in_item;
  uitp_pkg::in_item_t hold_item;
  uitp_pkg::result_t  res;
  uitp_pkg::result_t  out_data;
  logic               hold_valid;
  logic               take;
  logic               res_valid;
  logic               out_free;

  assign in_item.data_byte    = in_req.data_byte;
  assign in_item.record_start = in_req.record_start;
  assign take                 = hold_valid && out_free;

  uitp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_item    (in_item),
    .in_ready   (in_req.ready),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  uitp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (hold_item),
    .res_valid (res_valid),
    .res       (res)
  );

  uitp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (res_valid),
    .load_res   (res),
    .free       (out_free),
    .out_valid  (out_res.valid),
    .out_res    (out_data),
    .out_ready  (out_res.ready)
  );

  assign out_res.result_kind    = out_data.result_kind;
  assign out_res.name_char      = out_data.name_char;
  assign out_res.warn_level     = out_data.warn_level;
  assign out_res.member_class   = out_data.member_class;
  assign out_res.member_since   = out_data.member_since;
  assign out_res.online_since   = out_data.online_since;
  assign out_res.idle_seconds   = out_data.idle_seconds;
  assign out_res.session_length = out_data.session_length;
  assign out_res.bytes_used     = out_data.bytes_used;
  assign out_res.unknown_seen   = out_data.unknown_seen;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for user_info_tlv_parser_core. Streams directed and
// random user-information records through the request channel, predicts the
// name-character and summary results in step with each accepted byte, and
// checks every returned result field by field under random idling on both
// sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  uitp_in_if  in_req ();
  uitp_out_if out_res ();

  user_info_tlv_parser_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  uitp_pkg::in_item_t byte_q[$];
  uitp_pkg::in_item_t record_q[$];
  uitp_pkg::result_t  result_q[$];

  int errors = 0;
  int mismatches = 0;
  int chars_checked = 0;
  int summaries_checked = 0;
  int saturated_seen = 0;
  int unknown_summaries = 0;
  int records_started = 0;

  // parser state mirror
  uitp_pkg::phase_t ph;
  logic [7:0]  name_left;
  logic [15:0] ent_left;
  logic [15:0] ent_type;
  logic [15:0] ent_len;
  logic [15:0] val_pos;
  logic [31:0] val_acc;
  logic        class_got;
  logic [15:0] warn_reg;
  logic [15:0] class_reg;
  logic [31:0] since_reg;
  logic [31:0] online_reg;
  logic [15:0] idle_reg;
  logic [31:0] sess_reg;
  logic [15:0] byte_cnt;
  logic        unk_reg;

  function automatic int field_width(input logic [15:0] t);
    case (t)
      uitp_pkg::TYPE_CLASS, uitp_pkg::TYPE_IDLE: field_width = 2;
      uitp_pkg::TYPE_SINCE, uitp_pkg::TYPE_ONLINE,
      uitp_pkg::TYPE_SESS_A, uitp_pkg::TYPE_SESS_B: field_width = 4;
      default: field_width = 0;
    endcase
  endfunction

  task automatic clear_record();
    ph = uitp_pkg::PH_IDLE;
    name_left = '0;
    ent_left = '0;
    ent_type = '0;
    ent_len = '0;
    val_pos = '0;
    val_acc = '0;
    class_got = 1'b0;
    warn_reg = '0;
    class_reg = '0;
    since_reg = '0;
    online_reg = '0;
    idle_reg = '0;
    sess_reg = '0;
    byte_cnt = '0;
    unk_reg = 1'b0;
  endtask

  task automatic push_summary();
    uitp_pkg::result_t r;
    r = '0;
    r.result_kind = uitp_pkg::KIND_SUMMARY;
    r.warn_level = warn_reg;
    r.member_class = class_reg;
    r.member_since = since_reg;
    r.online_since = online_reg;
    r.idle_seconds = idle_reg;
    r.session_length = sess_reg;
    r.bytes_used = byte_cnt;
    r.unknown_seen = unk_reg;
    result_q.push_back(r);
    ph = uitp_pkg::PH_DONE;
  endtask

  task automatic close_entry();
    case (ent_type)
      uitp_pkg::TYPE_CLASS: begin
        if (!class_got) begin
          class_reg = val_acc[15:0];
          class_got = 1'b1;
        end
      end
      uitp_pkg::TYPE_SINCE: since_reg = val_acc;
      uitp_pkg::TYPE_ONLINE: online_reg = val_acc;
      uitp_pkg::TYPE_IDLE: idle_reg = val_acc[15:0];
      uitp_pkg::TYPE_SESS_A, uitp_pkg::TYPE_SESS_B: sess_reg = val_acc;
      default: unk_reg = 1'b1;
    endcase
    ent_left = ent_left - 16'd1;
    if (ent_left == 16'd0) begin
      push_summary();
    end else begin
      ph = uitp_pkg::PH_TYP_HI;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic st);
    uitp_pkg::result_t r;
    int w;
    if (st) begin
      clear_record();
      records_started++;
      byte_cnt = 16'd1;
      name_left = b;
      ph = (b != 8'd0) ? uitp_pkg::PH_NAME : uitp_pkg::PH_WARN_HI;
    end else if (ph != uitp_pkg::PH_IDLE && ph != uitp_pkg::PH_DONE) begin
      if (byte_cnt != uitp_pkg::COUNT_MAX) byte_cnt = byte_cnt + 16'd1;
      case (ph)
        uitp_pkg::PH_NAME: begin
          r = '0;
          r.result_kind = uitp_pkg::KIND_CHAR;
          r.name_char = b;
          result_q.push_back(r);
          name_left = name_left - 8'd1;
          if (name_left == 8'd0) ph = uitp_pkg::PH_WARN_HI;
        end
        uitp_pkg::PH_WARN_HI: begin
          warn_reg = {b, 8'h00};
          ph = uitp_pkg::PH_WARN_LO;
        end
        uitp_pkg::PH_WARN_LO: begin
          warn_reg[7:0] = b;
          ph = uitp_pkg::PH_CNT_HI;
        end
        uitp_pkg::PH_CNT_HI: begin
          ent_left = {b, 8'h00};
          ph = uitp_pkg::PH_CNT_LO;
        end
        uitp_pkg::PH_CNT_LO: begin
          ent_left[7:0] = b;
          if (ent_left == 16'd0) push_summary();
          else ph = uitp_pkg::PH_TYP_HI;
        end
        uitp_pkg::PH_TYP_HI: begin
          ent_type = {b, 8'h00};
          ph = uitp_pkg::PH_TYP_LO;
        end
        uitp_pkg::PH_TYP_LO: begin
          ent_type[7:0] = b;
          ph = uitp_pkg::PH_LEN_HI;
        end
        uitp_pkg::PH_LEN_HI: begin
          ent_len = {b, 8'h00};
          ph = uitp_pkg::PH_LEN_LO;
        end
        uitp_pkg::PH_LEN_LO: begin
          ent_len[7:0] = b;
          val_pos = '0;
          val_acc = '0;
          if (ent_len == 16'd0) close_entry();
          else ph = uitp_pkg::PH_VALUE;
        end
        default: begin
          w = field_width(ent_type);
          if (int'(val_pos) < w) val_acc = val_acc | ({24'd0, b} << (8 * (w - 1 - val_pos)));
          val_pos = val_pos + 16'd1;
          if (val_pos == ent_len) close_entry();
        end
      endcase
    end
  endtask

  // stimulus builders
  task automatic push_raw(input logic [7:0] b, input logic st);
    uitp_pkg::in_item_t it;
    it.data_byte = b;
    it.record_start = st;
    byte_q.push_back(it);
  endtask

  task automatic put_byte(input logic [7:0] b);
    uitp_pkg::in_item_t it;
    it.data_byte = b;
    it.record_start = 1'b0;
    record_q.push_back(it);
  endtask

  task automatic begin_record(input logic [7:0] name_len, input logic [15:0] warn,
                              input logic [15:0] count);
    uitp_pkg::in_item_t it;
    record_q.delete();
    it.data_byte = name_len;
    it.record_start = 1'b1;
    record_q.push_back(it);
    for (int i = 0; i < name_len; i++) put_byte(8'($urandom_range(0, 255)));
    put_byte(warn[15:8]);
    put_byte(warn[7:0]);
    put_byte(count[15:8]);
    put_byte(count[7:0]);
  endtask

  task automatic add_entry(input logic [15:0] etype, input logic [15:0] len);
    put_byte(etype[15:8]);
    put_byte(etype[7:0]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic ship_record(input int keep);
    for (int i = 0; i < record_q.size() && i < keep; i++) byte_q.push_back(record_q[i]);
  endtask

  // idling control
  logic [6:0] cyc = '0;
  logic idle_on = 1'b1;
  logic calm = 1'b0;

  always @(posedge clk) begin
    cyc <= cyc + 7'd1;
    if (cyc == 7'd0) idle_on <= ($urandom_range(0, 3) != 0);
    calm <= (byte_q.size() < 120);
  end

  // request driver
  int src_hold = 0;
  uitp_pkg::in_item_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      src_hold = 0;
    end else begin
      if (in_req.valid && in_req.ready) parse_byte(in_req.data_byte, in_req.record_start);
      if (!in_req.valid || in_req.ready) begin
        if (src_hold > 0) begin
          src_hold--;
          in_req.valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_req.valid <= 1'b0;
        end else if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
          src_hold = $urandom_range(0, 3);
          in_req.valid <= 1'b0;
        end else begin
          nxt = byte_q.pop_front();
          in_req.valid <= 1'b1;
          in_req.data_byte <= nxt.data_byte;
          in_req.record_start <= nxt.record_start;
        end
      end
    end
  end

  // result monitor
  int sink_hold = 0;
  uitp_pkg::result_t got;
  uitp_pkg::result_t want;

  task automatic report_field(input string fname, input logic [31:0] e, input logic [31:0] a);
    mismatches++;
    errors++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, fname, e, a);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        got.result_kind = out_res.result_kind;
        got.name_char = out_res.name_char;
        got.warn_level = out_res.warn_level;
        got.member_class = out_res.member_class;
        got.member_since = out_res.member_since;
        got.online_since = out_res.online_since;
        got.idle_seconds = out_res.idle_seconds;
        got.session_length = out_res.session_length;
        got.bytes_used = out_res.bytes_used;
        got.unknown_seen = out_res.unknown_seen;
        if (result_q.size() == 0) begin
          mismatches++;
          errors++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: kind %0b char 0x%0h bytes_used %0d",
                     $realtime, got.result_kind, got.name_char, got.bytes_used);
        end else begin
          want = result_q.pop_front();
          if (want.result_kind == uitp_pkg::KIND_CHAR) chars_checked++;
          else begin
            summaries_checked++;
            if (want.bytes_used == uitp_pkg::COUNT_MAX) saturated_seen++;
            if (want.unknown_seen) unknown_summaries++;
          end
          if (got.result_kind !== want.result_kind)
            report_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
          if (got.name_char !== want.name_char)
            report_field("name_char", 32'(want.name_char), 32'(got.name_char));
          if (got.warn_level !== want.warn_level)
            report_field("warn_level", 32'(want.warn_level), 32'(got.warn_level));
          if (got.member_class !== want.member_class)
            report_field("member_class", 32'(want.member_class), 32'(got.member_class));
          if (got.member_since !== want.member_since)
            report_field("member_since", want.member_since, got.member_since);
          if (got.online_since !== want.online_since)
            report_field("online_since", want.online_since, got.online_since);
          if (got.idle_seconds !== want.idle_seconds)
            report_field("idle_seconds", 32'(want.idle_seconds), 32'(got.idle_seconds));
          if (got.session_length !== want.session_length)
            report_field("session_length", want.session_length, got.session_length);
          if (got.bytes_used !== want.bytes_used)
            report_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
          if (got.unknown_seen !== want.unknown_seen)
            report_field("unknown_seen", 32'(want.unknown_seen), 32'(got.unknown_seen));
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_res.ready <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
        sink_hold = $urandom_range(0, 3);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  initial begin
    int random_bytes;
    int pick;
    int nl;
    int cnt;
    int keep;
    int waited;
    logic [15:0] etype;
    logic [15:0] elen;

    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.data_byte = 8'h00;
    in_req.record_start = 1'b0;
    out_res.ready = 1'b0;
    clear_record();

    // drop: bytes before any record
    push_raw(8'hff, 1'b0);
    push_raw(8'h00, 1'b0);

    // empty name, no entries, then a stray byte after the summary
    begin_record(8'd0, 16'hffff, 16'd0);
    ship_record(record_q.size());
    push_raw(8'h5a, 1'b0);

    // every known type, empty and repeated class, short and long values, unknowns
    begin_record(8'd2, 16'h0000, 16'd9);
    record_q[1].data_byte = 8'h00;
    record_q[2].data_byte = 8'hff;
    add_entry(uitp_pkg::TYPE_CLASS, 16'd0);
    add_entry(uitp_pkg::TYPE_CLASS, 16'd2);
    add_entry(uitp_pkg::TYPE_SINCE, 16'd4);
    add_entry(uitp_pkg::TYPE_ONLINE, 16'd1);
    add_entry(uitp_pkg::TYPE_IDLE, 16'd5);
    add_entry(uitp_pkg::TYPE_SESS_A, 16'd3);
    add_entry(uitp_pkg::TYPE_SESS_B, 16'd4);
    add_entry(16'h0000, 16'd2);
    add_entry(16'hffff, 16'd0);
    ship_record(record_q.size());

    // restart in the middle of the name
    begin_record(8'd5, 16'h1234, 16'd1);
    add_entry(uitp_pkg::TYPE_SINCE, 16'd4);
    ship_record(3);

    // longest name, long unknown value
    begin_record(8'd255, 16'h8001, 16'd2);
    add_entry(16'h0101, 16'h0100);
    add_entry(uitp_pkg::TYPE_CLASS, 16'd2);
    ship_record(record_q.size());

    // entry count with a nonzero high byte
    begin_record(8'd1, 16'($urandom), 16'h0102);
    for (int i = 0; i < 16'h0102; i++) add_entry(16'($urandom_range(0, 17)), 16'd0);
    ship_record(record_q.size());

    random_bytes = 0;
    while (random_bytes < 300) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3)) push_raw(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        nl = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        begin_record(8'(nl), 16'($urandom), 16'(cnt));
        for (int k = 0; k < cnt; k++) begin
          case ($urandom_range(0, 9))
            0: etype = uitp_pkg::TYPE_CLASS;
            1: etype = uitp_pkg::TYPE_SINCE;
            2: etype = uitp_pkg::TYPE_ONLINE;
            3: etype = uitp_pkg::TYPE_IDLE;
            4: etype = uitp_pkg::TYPE_SESS_A;
            5: etype = uitp_pkg::TYPE_SESS_B;
            6: etype = 16'h0000;
            7: etype = 16'($urandom_range(5, 14));
            8: etype = 16'($urandom_range(17, 65535));
            default: etype = 16'hffff;
          endcase
          elen = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                 : $urandom_range(0, 6));
          add_entry(etype, elen);
        end
        keep = (pick == 1) ? $urandom_range(1, record_q.size()) : record_q.size();
        ship_record(keep);
        random_bytes += keep;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_req.valid) @(posedge clk);
    waited = 0;
    while (result_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (result_q.size() != 0) begin
      errors += result_q.size();
      $display("%0d expected results never arrived", result_q.size());
    end

    $display("%0d records started, %0d name characters and %0d summaries checked",
             records_started, chars_checked, summaries_checked);
    $display("%0d summaries with the unknown flag, %0d with a saturated byte count, %0d errors",
             unknown_summaries, saturated_seen, errors);
    if (errors == 0) begin
      $display("user_info_tlv_parser_core verification clean");
    end else begin
      $display("user_info_tlv_parser_core verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("user_info_tlv_parser_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/uitp_pkg.sv
hdl/uitp_if.sv
hdl/uitp_in_stage.sv
hdl/uitp_parse.sv
hdl/uitp_out_stage.sv
hdl/user_info_tlv_parser_core.sv
test/tb.sv
